FILE: rtl/core/pps_pkg.sv
// Shared types, constants and controller interface of the preemptive priority scheduler.
package pps_pkg;

    localparam int DEF_MAX_PROCS = 16;

    localparam int TIME_W  = 32;
    localparam int TICK_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int SLOT_W  = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [TICK_W-1:0] arrival_time;
        logic [TICK_W-1:0] burst_length;
        logic [PRIO_W-1:0] task_priority;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] task_slot;
        logic              idle_tick;
        logic              task_finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_finished;
        logic              table_full;
    } rsp_t;

    typedef struct packed {
        logic [TICK_W-1:0] ready_time;
        logic [TICK_W-1:0] work_left;
        logic [TICK_W-1:0] full_burst;
        logic [PRIO_W-1:0] rank;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic scan_step;
        logic update;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_op;
        logic count_zero;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/pps_ctrl.sv
// Sequencing state machine of the preemptive priority scheduler.
module pps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pps_pkg::ctrl_sts_t sts,
    output pps_pkg::ctrl_cmd_t cmd
);

    pps_pkg::state_t state_reg;
    pps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pps_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            pps_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.req_op == pps_pkg::OP_LOAD)
                    begin
                        state_next = pps_pkg::S_LOAD;
                    end
                    else if (sts.count_zero)
                    begin
                        state_next = pps_pkg::S_UPDATE;
                    end
                    else
                    begin
                        state_next = pps_pkg::S_SCAN;
                    end
                end
            end
            pps_pkg::S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = pps_pkg::S_FINISH;
            end
            pps_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = pps_pkg::S_DRAIN;
                end
            end
            pps_pkg::S_DRAIN:
            begin
                state_next = pps_pkg::S_UPDATE;
            end
            pps_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = pps_pkg::S_FINISH;
            end
            pps_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/pps_datapath.sv
// Task table, winner scan, counters and result register of the scheduler.
module pps_datapath #(
    parameter int MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::req_t      req,
    input  pps_pkg::ctrl_cmd_t cmd,
    output pps_pkg::ctrl_sts_t sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pps_pkg::rsp_t      rsp
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    pps_pkg::entry_t mem [MAX_PROCS];

    pps_pkg::req_t                   req_reg;
    logic [CNT_W-1:0]                loaded_reg;
    logic [CNT_W-1:0]                loaded_next;
    logic [CNT_W-1:0]                finished_reg;
    logic [CNT_W-1:0]                finished_next;
    logic [pps_pkg::TIME_W-1:0]      now_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            cand_valid_reg;
    logic [IDX_W-1:0]                cand_idx_reg;
    pps_pkg::entry_t                 rd_data_reg;
    logic                            found_reg;
    logic [IDX_W-1:0]                best_slot_reg;
    logic [pps_pkg::TICK_W-1:0]      best_ready_reg;
    logic [pps_pkg::TICK_W-1:0]      best_work_reg;
    logic [pps_pkg::TICK_W-1:0]      best_burst_reg;
    logic [pps_pkg::PRIO_W-1:0]      best_rank_reg;
    logic [pps_pkg::SLOT_W-1:0]      res_slot_reg;
    logic                            res_idle_reg;
    logic                            res_fin_reg;
    logic                            res_full_reg;
    logic [pps_pkg::TIME_W-1:0]      res_tat_reg;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    pps_pkg::rsp_t                   rsp_reg;

    logic                            table_full;
    logic [pps_pkg::TICK_W-1:0]      load_burst;
    logic                            eligible;
    logic                            better;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    pps_pkg::entry_t                 wr_data;
    logic                            tick_fin;
    logic [pps_pkg::TIME_W-1:0]      wait_time;

    assign table_full = (loaded_reg >= CNT_W'(MAX_PROCS));
    assign load_burst = (req_reg.burst_length == '0) ? pps_pkg::TICK_W'(1)
                                                      : req_reg.burst_length;

    assign eligible = cand_valid_reg && (rd_data_reg.work_left != '0) &&
                      ({{(pps_pkg::TIME_W - pps_pkg::TICK_W){1'b0}},
                        rd_data_reg.ready_time} <= now_reg);
    assign better   = !found_reg || (rd_data_reg.rank > best_rank_reg) ||
                      ((rd_data_reg.rank == best_rank_reg) &&
                       (rd_data_reg.ready_time < best_ready_reg));

    assign tick_fin = found_reg && (best_work_reg == pps_pkg::TICK_W'(1));

    assign sts.req_op     = req.op;
    assign sts.count_zero = (loaded_reg == '0);
    assign sts.scan_last  = (CNT_W'(idx_reg) == (loaded_reg - CNT_W'(1)));
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (cmd.load && !table_full)
        begin
            wr_en              = 1'b1;
            wr_addr            = loaded_reg[IDX_W-1:0];
            wr_data.ready_time = req_reg.arrival_time;
            wr_data.work_left  = load_burst;
            wr_data.full_burst = load_burst;
            wr_data.rank       = req_reg.task_priority;
        end
        else if (cmd.update && found_reg)
        begin
            wr_en              = 1'b1;
            wr_addr            = best_slot_reg;
            wr_data.ready_time = best_ready_reg;
            wr_data.work_left  = best_work_reg - pps_pkg::TICK_W'(1);
            wr_data.full_burst = best_burst_reg;
            wr_data.rank       = best_rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        if (cmd.load && !table_full)
        begin
            loaded_next = loaded_reg + CNT_W'(1);
        end
        if (cmd.update && tick_fin)
        begin
            finished_next = finished_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= '0;
            finished_reg   <= '0;
            now_reg        <= '0;
            idx_reg        <= '0;
            cand_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            loaded_reg     <= loaded_next;
            finished_reg   <= finished_next;
            cand_valid_reg <= cmd.scan_step;
            rsp_valid_reg  <= rsp_valid_next;
            if (cmd.update)
            begin
                now_reg <= now_reg + pps_pkg::TIME_W'(1);
            end
            if (cmd.accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (eligible)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (cmd.scan_step)
        begin
            cand_idx_reg <= idx_reg;
        end
        if (eligible && better)
        begin
            best_slot_reg  <= cand_idx_reg;
            best_ready_reg <= rd_data_reg.ready_time;
            best_work_reg  <= rd_data_reg.work_left;
            best_burst_reg <= rd_data_reg.full_burst;
            best_rank_reg  <= rd_data_reg.rank;
        end
        if (cmd.load)
        begin
            res_slot_reg <= table_full ? '0 : pps_pkg::SLOT_W'(loaded_reg[IDX_W-1:0]);
            res_idle_reg <= 1'b0;
            res_fin_reg  <= 1'b0;
            res_full_reg <= table_full;
            res_tat_reg  <= '0;
        end
        if (cmd.update)
        begin
            res_slot_reg <= found_reg ? pps_pkg::SLOT_W'(best_slot_reg) : '0;
            res_idle_reg <= !found_reg;
            res_fin_reg  <= tick_fin;
            res_full_reg <= 1'b0;
            res_tat_reg  <= now_reg + pps_pkg::TIME_W'(1) -
                            {{(pps_pkg::TIME_W - pps_pkg::TICK_W){1'b0}}, best_ready_reg};
        end
        if (cmd.emit)
        begin
            rsp_reg.task_slot       <= res_slot_reg;
            rsp_reg.idle_tick       <= res_idle_reg;
            rsp_reg.task_finished   <= res_fin_reg;
            rsp_reg.completion_time <= res_fin_reg ? now_reg : '0;
            rsp_reg.turnaround_time <= res_fin_reg ? res_tat_reg : '0;
            rsp_reg.waiting_time    <= res_fin_reg ? wait_time : '0;
            rsp_reg.all_finished    <= (finished_reg == loaded_reg);
            rsp_reg.table_full      <= res_full_reg;
        end
    end

    assign wait_time = res_tat_reg -
                       {{(pps_pkg::TIME_W - pps_pkg::TICK_W){1'b0}}, best_burst_reg};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/core/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: controller plus datapath.
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_stall   pps_pkg::req_t
//  rsp       out        rsp_valid / rsp_stall   pps_pkg::rsp_t
//
// A load request passes through the load and finish states; a tick request passes
// through the scan, drain, update and finish states, the scan reading one task table
// entry per cycle through one port. With no tasks loaded a tick skips scan and drain.
// Reset clears counters, time and handshake state; table entries are not cleared.
// A stalled response holds while the next request is accepted and worked on.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pps_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pps_pkg::rsp_t rsp
);

    pps_pkg::ctrl_cmd_t cmd;
    pps_pkg::ctrl_sts_t sts;

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pps_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
